// ===== rtl/slt_pkg.sv =====
package slt_pkg;

    localparam int KEY_W   = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic                    cmp_en;
        logic signed [KEY_W-1:0] cmp_key;
        logic                    upd_ins;
        logic                    upd_del;
        logic signed [KEY_W-1:0] ins_key;
    } slt_ctrl_t;

endpackage

// ===== rtl/slt_cell.sv =====
module slt_cell (
    input  logic                             clk,
    input  slt_pkg::slt_ctrl_t               ctrl,
    input  logic                             occupied,
    input  logic signed [slt_pkg::KEY_W-1:0] left_key,
    input  logic                             left_less,
    input  logic signed [slt_pkg::KEY_W-1:0] right_key,
    output logic signed [slt_pkg::KEY_W-1:0] cell_key,
    output logic                             less,
    output logic                             eq
);
    import slt_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    less_reg;
    logic                    less_next;
    logic                    eq_reg;
    logic                    eq_next;

    // compare phase: flags only meaningful for occupied cells
    always_comb
    begin
        less_next = less_reg;
        eq_next   = eq_reg;
        if (ctrl.cmp_en)
        begin
            less_next = occupied && (key_reg < ctrl.cmp_key);
            eq_next   = occupied && (key_reg == ctrl.cmp_key);
        end
    end

    // update phase: insert shifts up from the insertion point, delete shifts down
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.upd_ins && !less_reg)
        begin
            key_next = left_less ? ctrl.ins_key : left_key;
        end
        else if (ctrl.upd_del && !less_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        less_reg <= less_next;
        eq_reg   <= eq_next;
    end

    assign cell_key = key_reg;
    assign less     = less_reg;
    assign eq       = eq_reg;

endmodule

// ===== rtl/sorted_list_table.sv =====
// channel  | direction | handshake            | payload
// request  | in        | in_valid / in_ready  | req_type, key
// result   | out       | out_valid / out_ready| status, hit, entry_count, smallest_key, list_empty
//
// a transaction has an acceptance edge, where every cell compares its key with the
// request key, and an update edge, where the cells shift and the result register
// loads. a held result stalls the update edge until it is taken. reset clears the
// count and the handshake flags; cell contents are left undefined and are only read
// below the count. one request is in flight at a time.
module sorted_list_table #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [slt_pkg::REQ_W-1:0]           req_type,
    input  logic signed [slt_pkg::KEY_W-1:0]    key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [slt_pkg::STAT_W-1:0]          status,
    output logic                                hit,
    output logic [slt_pkg::COUNT_W-1:0]         entry_count,
    output logic signed [slt_pkg::KEY_W-1:0]    smallest_key,
    output logic                                list_empty
);
    import slt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    slt_ctrl_t               ctrl;
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]     less_vec;
    logic [CAPACITY-1:0]     eq_vec;
    logic [CAPACITY-1:0]     occ_vec;

    logic                    busy_reg;
    logic [REQ_W-1:0]        req_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic                    out_valid_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [STAT_W-1:0]       status_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic [COUNT_W-1:0]      entry_count_reg;
    logic signed [KEY_W-1:0] smallest_reg;
    logic signed [KEY_W-1:0] smallest_next;
    logic                    empty_reg;

    logic                    accept;
    logic                    upd_fire;
    logic                    full;
    logic                    any_eq;
    logic                    do_ins;
    logic                    do_del;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    // update edge waits until the result register is free or being emptied
    assign upd_fire = busy_reg && (!out_valid_reg || out_ready);
    assign full     = count_reg >= CNT_W'(CAPACITY);
    // keys are sorted, so any match means a match at the insertion point
    assign any_eq   = |eq_vec;
    assign do_ins   = upd_fire && (req_reg == REQ_INSERT) && !full;
    assign do_del   = upd_fire && (req_reg == REQ_DELETE) && any_eq;

    always_comb
    begin
        ctrl.cmp_en  = accept;
        ctrl.cmp_key = key;
        ctrl.upd_ins = do_ins;
        ctrl.upd_del = do_del;
        ctrl.ins_key = key_reg;
    end

    // the chain: each cell sees its lower neighbour for inserts and its
    // upper neighbour for deletes
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] l_key;
        logic                    l_less;
        logic signed [KEY_W-1:0] r_key;

        assign occ_vec[i] = CNT_W'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign l_key  = key_reg;
            assign l_less = 1'b1;
        end
        else
        begin : g_mid
            assign l_key  = cell_key[i-1];
            assign l_less = less_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_key = cell_key[i];
        end
        else
        begin : g_inner
            assign r_key = cell_key[i+1];
        end

        slt_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occ_vec[i]),
            .left_key  (l_key),
            .left_less (l_less),
            .right_key (r_key),
            .cell_key  (cell_key[i]),
            .less      (less_vec[i]),
            .eq        (eq_vec[i])
        );
    end

    // result of the request in flight, and the head of the store after it
    always_comb
    begin
        count_next    = count_reg;
        status_next   = ST_DONE;
        hit_next      = 1'b0;
        smallest_next = cell_key[0];
        case (req_reg)
            REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next    = count_reg + CNT_W'(1);
                    hit_next      = 1'b1;
                    smallest_next = less_vec[0] ? cell_key[0] : key_reg;
                end
            end
            REQ_DELETE:
            begin
                if (any_eq)
                begin
                    count_next    = count_reg - CNT_W'(1);
                    hit_next      = 1'b1;
                    smallest_next = less_vec[0] ? cell_key[0] : cell_key[1];
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            REQ_SEARCH:
            begin
                if (any_eq)
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
        if (count_next == '0)
        begin
            smallest_next = '0;
        end
    end

    // request capture and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (upd_fire)
            begin
                busy_reg  <= 1'b0;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= key;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            status_reg      <= status_next;
            hit_reg         <= hit_next;
            entry_count_reg <= COUNT_W'(count_next);
            smallest_reg    <= smallest_next;
            empty_reg       <= (count_next == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign hit          = hit_reg;
    assign entry_count  = entry_count_reg;
    assign smallest_key = smallest_reg;
    assign list_empty   = empty_reg;

    // store never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    // sorted store gives a prefix of less flags
    a_less_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (((less_vec >> 1) & ~less_vec) == '0))
        else $error("less flags not a prefix, store out of order");

    // a cell cannot be both below and equal to the request key
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((less_vec & eq_vec) == '0))
        else $error("less and equal flags overlap");

    // count moves by at most one per update
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> (count_reg == $past(count_reg)
                      || count_reg == $past(count_reg) + CNT_W'(1)
                      || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count jumped");

    // rejected insert leaves nothing inserted
    a_full_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> !hit)
        else $error("hit reported on rejected insert");

endmodule
